// File: sv/mks_pkg.sv
package mks_pkg;

    // matrix size defaults
    localparam int ROW_COUNT_DEF    = 4;
    localparam int COLUMN_COUNT_DEF = 4;

    // configuration register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_ROW0_CODES     = 3'd0;
    localparam logic [2:0] REG_ROW1_CODES     = 3'd1;
    localparam logic [2:0] REG_ROW2_CODES     = 3'd2;
    localparam logic [2:0] REG_ROW3_CODES     = 3'd3;
    localparam logic [2:0] REG_DEBOUNCE_TICKS = 3'd4;
    localparam logic [2:0] REG_SETTLE_TICKS   = 3'd5;

    localparam int PADDR_W = 5;

    // reset values of the configuration registers
    localparam logic [31:0] ROW0_CODES_RST     = 32'h2F39_3837; // '7' '8' '9' '/'
    localparam logic [31:0] ROW1_CODES_RST     = 32'h2A36_3534; // '4' '5' '6' '*'
    localparam logic [31:0] ROW2_CODES_RST     = 32'h2D33_3231; // '1' '2' '3' '-'
    localparam logic [31:0] ROW3_CODES_RST     = 32'h2B3D_3063; // 'c' '0' '=' '+'
    localparam logic [15:0] DEBOUNCE_TICKS_RST = 16'd20;
    localparam logic [7:0]  SETTLE_TICKS_RST   = 8'd1;

    // result word layout
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 16;
    localparam int DRIVE_LSB   = 0;
    localparam int VALID_BIT   = 4;
    localparam int CODE_LSB    = 5;

endpackage

// File: sv/matrix_keypad_scanner_top.sv
// channel  | direction | handshake                 | payload
// s_*      | in        | s_tvalid / s_tready       | s_tdata[3:0] row_levels
// m_*      | out       | m_tvalid / m_tready       | m_tdata -> drive, valid flag, key code
// apb      | in/out    | psel, penable, pready=1   | 6 registers at 4*i, 32-bit data
//
// One tick word is accepted per cycle while s_tready is high; its result word
// is in the output register in the next cycle. The scan state and the result
// register update at the same edge, so the only loop is the state update of one tick.
// s_tready stays high while the output register is empty or being drained, so a
// stall on m_tready holds the result and stops intake only while it lasts.
// Reset clears the scan state to column 0 and loads the default key map.
module matrix_keypad_scanner_top
    import mks_pkg::*;
#(
    parameter int ROW_COUNT    = ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // [3:0] row_levels, [7:4] zero
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // [3:0] column_drive, [4] key_valid,
                                             // [12:5] key_code, [15:13] zero
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [1:0] {
        PH_SCAN,
        PH_HOLD,
        PH_DEBOUNCE
    } phase_t;

    localparam logic [3:0] ROW_MASK = 4'((5'd1 << ROW_COUNT) - 5'd1);
    localparam logic [2:0] COL_LAST = 3'(COLUMN_COUNT);

    phase_t      phase_reg, phase_next;
    logic [1:0]  col_reg, col_next;
    logic [7:0]  settle_reg, settle_next;
    logic [15:0] deb_reg, deb_next;
    logic [1:0]  held_reg, held_next;

    logic [31:0] codes_reg [4];
    logic [15:0] deb_ticks_reg;
    logic [7:0]  settle_ticks_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic        accept;
    logic        cfg_wr;
    logic [3:0]  rows;
    logic [3:0]  pressed;
    logic [1:0]  low_row;
    logic [2:0]  col_inc;
    logic [3:0]  drive;
    logic        key_valid;
    logic [7:0]  key_code;
    logic [31:0] row_word;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;

    assign rows     = s_tdata[3:0];
    assign pressed  = ~rows & ROW_MASK;
    assign col_inc  = {1'b0, col_reg} + 3'd1;
    assign row_word = codes_reg[held_reg];

    // lowest pressed row wins
    always_comb
    begin
        low_row = 2'd0;
        for (int i = 3; i >= 0; i--)
        begin
            if (pressed[i])
            begin
                low_row = 2'(i);
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        col_next    = col_reg;
        settle_next = settle_reg;
        deb_next    = deb_reg;
        held_next   = held_reg;
        drive       = ~(4'b0001 << col_reg);
        key_valid   = 1'b0;
        key_code    = 8'd0;
        unique case (phase_reg)
            PH_HOLD:
            begin
                if (rows[held_reg])
                begin
                    phase_next = PH_DEBOUNCE;
                    deb_next   = 16'd0;
                end
            end
            PH_DEBOUNCE:
            begin
                if (deb_reg < deb_ticks_reg)
                begin
                    deb_next = deb_reg + 16'd1;
                end
                else
                begin
                    key_valid   = 1'b1;
                    key_code    = row_word[{col_reg, 3'b000} +: 8];
                    drive       = 4'hF;
                    phase_next  = PH_SCAN;
                    col_next    = 2'd0;
                    settle_next = 8'd0;
                end
            end
            default:
            begin
                phase_next = PH_SCAN;
                if (settle_reg < settle_ticks_reg)
                begin
                    settle_next = settle_reg + 8'd1;
                end
                else if (pressed != 4'd0)
                begin
                    held_next  = low_row;
                    phase_next = PH_HOLD;
                end
                else
                begin
                    col_next    = (col_inc >= COL_LAST) ? 2'd0 : col_inc[1:0];
                    settle_next = 8'd0;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SCAN;
            col_reg       <= 2'd0;
            settle_reg    <= 8'd0;
            deb_reg       <= 16'd0;
            held_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                col_reg       <= col_next;
                settle_reg    <= settle_next;
                deb_reg       <= deb_next;
                held_reg      <= held_next;
                out_valid_reg <= 1'b1;
                out_data_reg  <= {3'd0, key_code, key_valid, drive};
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg[0]     <= ROW0_CODES_RST;
            codes_reg[1]     <= ROW1_CODES_RST;
            codes_reg[2]     <= ROW2_CODES_RST;
            codes_reg[3]     <= ROW3_CODES_RST;
            deb_ticks_reg    <= DEBOUNCE_TICKS_RST;
            settle_ticks_reg <= SETTLE_TICKS_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_ROW0_CODES:     codes_reg[0]     <= pwdata;
                REG_ROW1_CODES:     codes_reg[1]     <= pwdata;
                REG_ROW2_CODES:     codes_reg[2]     <= pwdata;
                REG_ROW3_CODES:     codes_reg[3]     <= pwdata;
                REG_DEBOUNCE_TICKS: deb_ticks_reg    <= pwdata[15:0];
                REG_SETTLE_TICKS:   settle_ticks_reg <= pwdata[7:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_ROW0_CODES:     prdata = codes_reg[0];
            REG_ROW1_CODES:     prdata = codes_reg[1];
            REG_ROW2_CODES:     prdata = codes_reg[2];
            REG_ROW3_CODES:     prdata = codes_reg[3];
            REG_DEBOUNCE_TICKS: prdata = {16'd0, deb_ticks_reg};
            REG_SETTLE_TICKS:   prdata = {24'd0, settle_ticks_reg};
            default:            prdata = 32'd0;
        endcase
    end

endmodule

// File: sv/mks_checker.sv
module mks_checker
    import mks_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    logic [3:0] drive;
    logic       key_valid;
    logic [7:0] key_code;

    assign drive     = m_tdata[DRIVE_LSB +: 4];
    assign key_valid = m_tdata[VALID_BIT];
    assign key_code  = m_tdata[CODE_LSB +: 8];

    // hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // release all columns on the report tick
    a_report_drive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && key_valid |-> drive == 4'hF)
        else $error("columns driven on a report word");

    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !key_valid |-> key_code == 8'd0)
        else $error("key code set without a report");

    // exactly one column low on every non-report word
    a_one_column: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !key_valid |-> $countones(~drive) == 1)
        else $error("not exactly one column driven");

endmodule

bind matrix_keypad_scanner_top mks_checker u_mks_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/matrix_keypad_scanner_top_tb.sv
module matrix_keypad_scanner_top_tb;
    import mks_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_COUNT = 9;

    typedef enum logic [1:0] {
        SCANNING   = 2'd0,
        HOLDING    = 2'd1,
        DEBOUNCING = 2'd2
    } scan_phase_e;

    typedef struct packed {
        logic [3:0] drive;
        logic       valid;
        logic [7:0] code;
    } key_result_t;

    typedef enum logic {
        STEP_TICK,
        STEP_WRITE
    } step_kind_e;

    typedef struct packed {
        step_kind_e  kind;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        logic [3:0]  rows;
        logic        typed;
        key_result_t want;
    } drill_step_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [31:0]            pwdata = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // typed expectation travels alongside the tick word
    logic        tick_typed = 1'b0;
    key_result_t tick_want = '0;

    // predictor copy of the scanner
    logic [31:0] key_map [4];
    logic [15:0] debounce_limit;
    logic [7:0]  settle_limit;
    logic [1:0]  column;
    scan_phase_e phase;
    logic [7:0]  settle_cnt;
    logic [15:0] debounce_cnt;
    logic [1:0]  held_row;

    key_result_t pending_keys [$];
    int          mismatch_count = 0;
    int          ticks_sent = 0;
    int          keys_reported = 0;
    int          cycle_count = 0;
    int          idle_style = 1;

    drill_step_t drill_steps [27] = '{
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b1, '{4'hE, 1'b0, 8'h00}},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b1, '{4'hE, 1'b0, 8'h00}},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b1, '{4'hD, 1'b0, 8'h00}},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'h7, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'h0, 1'b0, '0},
        // release of row 3 while the other rows are pressed
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'h8, 1'b0, '0},
        // lower the debounce interval while a count is running
        '{STEP_WRITE, REG_DEBOUNCE_TICKS, 32'h0, 4'h0, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'h0, 1'b1, '{4'hF, 1'b1, 8'h30}},
        '{STEP_WRITE, REG_SETTLE_TICKS,   32'h0, 4'h0, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hE, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b1, '{4'hF, 1'b1, 8'h37}},
        '{STEP_WRITE, REG_ROW2_CODES,     32'hFFFF_FFFF, 4'h0, 1'b0, '0},
        '{STEP_WRITE, REG_ROW1_CODES,     32'h0, 4'h0, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hB, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b1, '{4'hF, 1'b1, 8'hFF}},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hD, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'hF, 1'b1, '{4'hF, 1'b1, 8'h00}},
        '{STEP_WRITE, REG_DEBOUNCE_TICKS, 32'h0000_FFFF, 4'h0, 1'b0, '0},
        '{STEP_WRITE, REG_SETTLE_TICKS,   32'h0000_00FF, 4'h0, 1'b0, '0},
        // press ignored while the column settles
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'h0, 1'b0, '0},
        '{STEP_TICK,  REG_ROW0_CODES,     32'h0, 4'h5, 1'b0, '0}
    };

    matrix_keypad_scanner_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),  // [3:0] row_levels, [7:4] zero
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),  // [3:0] column_drive, [4] key_valid, [12:5] key_code
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic key_result_t scan_tick(input logic [3:0] rows);
        key_result_t r;
        logic [3:0]  pressed;
        r.drive = ~(4'b0001 << column);
        r.valid = 1'b0;
        r.code  = 8'h00;
        case (phase)
            HOLDING:
            begin
                if (rows[held_row])
                begin
                    phase        = DEBOUNCING;
                    debounce_cnt = '0;
                end
            end
            DEBOUNCING:
            begin
                if (debounce_cnt < debounce_limit)
                    debounce_cnt = debounce_cnt + 16'd1;
                else
                begin
                    r.valid    = 1'b1;
                    r.code     = key_map[held_row][{column, 3'b000} +: 8];
                    r.drive    = 4'hF;
                    phase      = SCANNING;
                    column     = '0;
                    settle_cnt = '0;
                end
            end
            default:
            begin
                phase = SCANNING;
                if (settle_cnt < settle_limit)
                    settle_cnt = settle_cnt + 8'd1;
                else
                begin
                    pressed = ~rows & 4'((1 << ROW_COUNT_DEF) - 1);
                    if (pressed != 4'h0)
                    begin
                        // lowest pressed row wins
                        for (int i = 3; i >= 0; i--)
                            if (pressed[i])
                                held_row = 2'(i);
                        phase = HOLDING;
                    end
                    else
                    begin
                        column     = (column == 2'(COLUMN_COUNT_DEF - 1)) ? 2'd0 : column + 2'd1;
                        settle_cnt = '0;
                    end
                end
            end
        endcase
        return r;
    endfunction

    function automatic logic [31:0] shadow_reg(input logic [2:0] idx);
        case (idx)
            REG_ROW0_CODES:     return key_map[0];
            REG_ROW1_CODES:     return key_map[1];
            REG_ROW2_CODES:     return key_map[2];
            REG_ROW3_CODES:     return key_map[3];
            REG_DEBOUNCE_TICKS: return {16'h0, debounce_limit};
            REG_SETTLE_TICKS:   return {24'h0, settle_limit};
            default:            return 32'h0;
        endcase
    endfunction

    function automatic int draw_gap();
        case (idle_style)
            0:       return 0;
            1:       return $urandom_range(0, 17);
            default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        endcase
    endfunction

    task automatic note_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0s: expected %0h, got %0h", what, want, got);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ROW0_CODES:     key_map[0] = value;
            REG_ROW1_CODES:     key_map[1] = value;
            REG_ROW2_CODES:     key_map[2] = value;
            REG_ROW3_CODES:     key_map[3] = value;
            REG_DEBOUNCE_TICKS: debounce_limit = value[15:0];
            REG_SETTLE_TICKS:   settle_limit = value[7:0];
            default:            ;
        endcase
    endtask

    task automatic check_registers();
        logic [2:0] idx;
        for (int i = 0; i <= int'(REG_SETTLE_TICKS); i++)
        begin
            idx = 3'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {idx, 2'b00};
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            if (prdata !== shadow_reg(idx))
                note_mismatch($sformatf("register %0d readback", i), shadow_reg(idx), prdata);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic send_tick(input logic [3:0] rows, input logic typed, input key_result_t want);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= {4'h0, rows};
        tick_typed <= typed;
        tick_want  <= want;
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    // drop valid and hold until every outstanding key word is back
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_keys.size() != 0);
    endtask

    // one press-hold-release sequence with random content, or a burst of noise
    task automatic key_episode();
        logic [3:0] press;
        int         hold_len;
        int         release_len;
        if ($urandom_range(0, 9) < 2)
        begin
            repeat ($urandom_range(1, 6)) send_tick(4'($urandom), 1'b0, '0);
            return;
        end
        repeat ($urandom_range(0, 4)) send_tick(4'hF, 1'b0, '0);
        press    = 4'($urandom_range(0, 14));
        hold_len = settle_limit + 1 + $urandom_range(0, 4);
        if (hold_len > 12)
            hold_len = 12;
        repeat (hold_len) send_tick(press, 1'b0, '0);
        release_len = ((debounce_limit > 40) ? 40 : debounce_limit) + 1 + $urandom_range(0, 2);
        repeat (release_len)
            send_tick(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'hF, 1'b0, '0);
    endtask

    always @(posedge clk)
    begin
        key_result_t want;
        key_result_t got;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                want = scan_tick(s_tdata[3:0]);
                if (tick_typed)
                    want = tick_want;
                pending_keys.push_back(want);
            end
            if (m_tvalid && m_tready)
            begin
                got.drive = m_tdata[DRIVE_LSB +: 4];
                got.valid = m_tdata[VALID_BIT];
                got.code  = m_tdata[CODE_LSB +: 8];
                if (got.valid)
                    keys_reported++;
                if (pending_keys.size() == 0)
                    note_mismatch("unexpected word", 0, int'(m_tdata));
                else
                begin
                    want = pending_keys.pop_front();
                    if (got.drive !== want.drive)
                        note_mismatch("column_drive", int'(want.drive), int'(got.drive));
                    if (got.valid !== want.valid)
                        note_mismatch("key_valid", int'(want.valid), int'(got.valid));
                    if (got.code !== want.code)
                        note_mismatch("key_code", int'(want.code), int'(got.code));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        int gap;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    initial
    begin
        int          phase_end;
        logic [31:0] codes;
        key_map[0]     = ROW0_CODES_RST;
        key_map[1]     = ROW1_CODES_RST;
        key_map[2]     = ROW2_CODES_RST;
        key_map[3]     = ROW3_CODES_RST;
        debounce_limit = DEBOUNCE_TICKS_RST;
        settle_limit   = SETTLE_TICKS_RST;
        column         = '0;
        phase          = SCANNING;
        settle_cnt     = '0;
        debounce_cnt   = '0;
        held_row       = '0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_registers();

        foreach (drill_steps[i])
        begin
            if (drill_steps[i].kind == STEP_WRITE)
            begin
                wait_drain();
                reg_write(drill_steps[i].reg_idx, drill_steps[i].value);
            end
            else
                send_tick(drill_steps[i].rows, drill_steps[i].typed, drill_steps[i].want);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            wait_drain();
            for (int r = 0; r < 4; r++)
            begin
                if (p == 0 || $urandom_range(0, 2) == 0)
                begin
                    case ($urandom_range(0, 5))
                        0:       codes = 32'h0000_0000;
                        1:       codes = 32'hFFFF_FFFF;
                        default: codes = $urandom;
                    endcase
                    case (r)
                        0:       reg_write(REG_ROW0_CODES, codes);
                        1:       reg_write(REG_ROW1_CODES, codes);
                        2:       reg_write(REG_ROW2_CODES, codes);
                        default: reg_write(REG_ROW3_CODES, codes);
                    endcase
                end
            end
            // the widest intervals get one phase each, cut short by the next
            if (p == 2)
                reg_write(REG_DEBOUNCE_TICKS, 32'h0000_FFFF);
            else if ($urandom_range(0, 4) == 0)
                reg_write(REG_DEBOUNCE_TICKS, 32'($urandom_range(0, 40)));
            else
                reg_write(REG_DEBOUNCE_TICKS, 32'($urandom_range(0, 6)));
            if (p == 4)
                reg_write(REG_SETTLE_TICKS, 32'h0000_00FF);
            else
                reg_write(REG_SETTLE_TICKS, 32'($urandom_range(0, 3)));
            check_registers();

            idle_style = (p == 0) ? 0 : $urandom_range(0, 2);
            phase_end  = ticks_sent + ((p == 2 || p == 4) ? 30 : 45);
            while (ticks_sent < phase_end)
            begin
                if ($urandom_range(0, 11) == 0)
                    wait_drain();
                key_episode();
            end
        end

        wait_drain();
        repeat (4) @(posedge clk);
        if (pending_keys.size() != 0)
            note_mismatch("words still outstanding", 0, pending_keys.size());
        $display("%0d row ticks over %0d register settings, %0d key reports checked",
                 ticks_sent, PHASE_COUNT + 1, keys_reported);
        $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/mks_pkg.sv
sv/matrix_keypad_scanner_top.sv
sv/mks_checker.sv
tb/matrix_keypad_scanner_top_tb.sv
